// File: sv/sgfp_pkg.sv
`timescale 1ns / 1ps

package sgfp_pkg;

    // Command opcodes
    localparam logic [2:0] OP_CLEAR    = 3'd0;
    localparam logic [2:0] OP_FILL_TOP = 3'd1;
    localparam logic [2:0] OP_FILL_LOW = 3'd2;
    localparam logic [2:0] OP_DRAW     = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;

    // Glyph cell geometry
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;

    // Coordinate widths: signed field plus head room for the scaled cell
    localparam int X_W = 11;
    localparam int Y_W = 10;

    // Column-major glyph bitmap, bit r of column c is row r
    typedef logic [0:GLYPH_COLS-1][GLYPH_ROWS-1:0] glyph_t;

    typedef struct packed {
        logic   found;
        glyph_t cols;
    } font_hit_t;

    // Sequencer to glyph stepper
    typedef struct packed {
        logic start;
        logic advance;
    } step_ctrl_t;

    // Glyph stepper to sequencer
    typedef struct packed {
        logic lit;
        logic last;
    } step_stat_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SWEEP,
        ST_READ,
        ST_DRAW_PIX,
        ST_DRAW_WR,
        ST_DONE
    } state_t;

    // Look up a character in the 19-entry font ROM
    function automatic font_hit_t font_lookup(input logic [7:0] code);
        font_hit_t hit;
        hit.found = 1'b1;
        case (code)
            8'h20: hit.cols = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00}; // space
            8'h2C: hit.cols = {7'h00, 7'h50, 7'h30, 7'h00, 7'h00}; // comma
            8'h48: hit.cols = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F}; // H
            8'h49: hit.cols = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00}; // I
            8'h52: hit.cols = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46}; // R
            8'h53: hit.cols = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31}; // S
            8'h54: hit.cols = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01}; // T
            8'h61: hit.cols = {7'h20, 7'h54, 7'h54, 7'h54, 7'h78}; // a
            8'h65: hit.cols = {7'h38, 7'h54, 7'h54, 7'h54, 7'h18}; // e
            8'h68: hit.cols = {7'h7F, 7'h08, 7'h04, 7'h04, 7'h78}; // h
            8'h69: hit.cols = {7'h00, 7'h44, 7'h7D, 7'h40, 7'h00}; // i
            8'h6B: hit.cols = {7'h7F, 7'h10, 7'h28, 7'h44, 7'h00}; // k
            8'h6C: hit.cols = {7'h00, 7'h41, 7'h7F, 7'h40, 7'h00}; // l
            8'h6D: hit.cols = {7'h7C, 7'h04, 7'h18, 7'h04, 7'h78}; // m
            8'h6E: hit.cols = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h78}; // n
            8'h6F: hit.cols = {7'h38, 7'h44, 7'h44, 7'h44, 7'h38}; // o
            8'h72: hit.cols = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h08}; // r
            8'h74: hit.cols = {7'h04, 7'h3F, 7'h44, 7'h40, 7'h20}; // t
            8'h79: hit.cols = {7'h0C, 7'h50, 7'h50, 7'h50, 7'h3C}; // y
            default:
            begin
                hit.found = 1'b0;
                hit.cols  = '0;
            end
        endcase
        return hit;
    endfunction

endpackage

// File: sv/sgfp_if.sv
`timescale 1ns / 1ps

// Command channel
interface sgfp_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        opcode;
    logic [7:0]        char_code;
    logic signed [9:0] x_pos;
    logic signed [7:0] y_pos;
    logic [9:0]        read_index;

    modport source (output valid, opcode, char_code, x_pos, y_pos, read_index, input ready);
    modport sink   (input valid, opcode, char_code, x_pos, y_pos, read_index, output ready);
endinterface

// Response channel
interface sgfp_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

// Configuration write channel
interface sgfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] glyph_scale;

    modport source (output valid, glyph_scale, input ready);
    modport sink   (input valid, glyph_scale, output ready);
endinterface

// File: sv/scaled_glyph_framebuffer_painter.sv
`timescale 1ns / 1ps

// Channel  Modport  Payload                                     Handshake
// cmd      sink     opcode, char_code, x_pos, y_pos, read_index valid/ready
// rsp      source   read_data (one per command)                 valid/ready
// cfg      sink     glyph_scale                                 valid/ready, always ready
//
// Clear and both fills sweep the frame memory, one byte per cycle, over all W*ceil(H/8) bytes.
// Draw visits every glyph pixel; a lit glyph pixel covers a scale x scale square, and each
// on-screen square pixel gets a read-modify-write on the frame memory. Unknown codes and
// scale 0 finish without drawing. After reset a clearing pass over the whole frame memory
// runs before the first command.
// A finished result waits in the output register; a new command is taken meanwhile.
module scaled_glyph_framebuffer_painter #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64,
    parameter int ZONE_SPLIT_ROW = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    sgfp_cmd_if.sink          cmd,
    sgfp_rsp_if.source        rsp,
    sgfp_cfg_if.sink          cfg
);

    localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COL_W       = $clog2(DISPLAY_WIDTH);
    localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int ROW_W       = $clog2(PAGE_COUNT * 8 + 1);
    localparam int SPLIT_CLIP  = (ZONE_SPLIT_ROW < DISPLAY_HEIGHT) ? ZONE_SPLIT_ROW
                                                                   : DISPLAY_HEIGHT;
    localparam int XW          = sgfp_pkg::X_W;
    localparam int YW          = sgfp_pkg::Y_W;

    sgfp_pkg::state_t        state_reg, state_next;

    logic [3:0]              scale_reg;

    logic [ADDR_W-1:0]       sweep_addr_reg;
    logic [COL_W-1:0]        sweep_col_reg;
    logic [PAGE_W-1:0]       sweep_page_reg;
    logic                    sweep_last;
    logic [ROW_W-1:0]        fill_first_reg;
    logic [ROW_W-1:0]        fill_last_reg;
    logic [7:0]              fill_byte;

    logic                    rd_ok_reg;
    logic [7:0]              res_data_reg;
    logic                    out_valid_reg;
    logic [7:0]              out_data_reg;
    logic                    done_take;
    logic                    cmd_fire;

    logic [7:0]              frame_mem [STORE_BYTES];
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [7:0]              mem_wdata;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [7:0]              mem_rdata_reg;

    sgfp_pkg::font_hit_t     font_hit;
    sgfp_pkg::step_ctrl_t    step_ctrl;
    sgfp_pkg::step_stat_t    step_stat;
    logic signed [XW-1:0]    px;
    logic signed [YW-1:0]    py;
    logic                    on_screen;
    logic                    draw_hit;
    logic [ADDR_W-1:0]       draw_addr;
    logic [7:0]              draw_mask;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign font_hit  = sgfp_pkg::font_lookup(cmd.char_code);
    assign done_take = (state_reg == sgfp_pkg::ST_DONE) && (!out_valid_reg || rsp.ready);

    // Glyph position stepper
    sgfp_glyph_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (step_ctrl),
        .scale (scale_reg),
        .x0    (XW'(cmd.x_pos)),
        .y0    (YW'(cmd.y_pos)),
        .cols  (font_hit.cols),
        .stat  (step_stat),
        .px    (px),
        .py    (py)
    );

    // Clip the current pixel and form its byte address and bit mask
    assign on_screen = !px[XW-1] && (px < $signed(XW'(DISPLAY_WIDTH))) &&
                       !py[YW-1] && (py < $signed(YW'(DISPLAY_HEIGHT)));
    assign draw_hit  = step_stat.lit && on_screen;
    assign draw_addr = ADDR_W'(int'(py[YW-2:3]) * DISPLAY_WIDTH + int'(px[XW-2:0]));
    assign draw_mask = 8'd1 << py[2:0];

    // Light the rows of the current sweep page that fall in the band
    always_comb
    begin
        logic [ROW_W-1:0] row;
        fill_byte = '0;
        for (int b = 0; b < 8; b++)
        begin
            row = ROW_W'({sweep_page_reg, 3'(b)});
            fill_byte[b] = (row >= fill_first_reg) && (row < fill_last_reg);
        end
    end

    assign sweep_last = (sweep_addr_reg == ADDR_W'(STORE_BYTES - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sgfp_pkg::ST_INIT:
            begin
                if (sweep_last)
                    state_next = sgfp_pkg::ST_IDLE;
            end
            sgfp_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd.opcode)
                        sgfp_pkg::OP_CLEAR, sgfp_pkg::OP_FILL_TOP, sgfp_pkg::OP_FILL_LOW:
                            state_next = sgfp_pkg::ST_SWEEP;
                        sgfp_pkg::OP_DRAW:
                            state_next = (font_hit.found && scale_reg != 4'd0) ?
                                         sgfp_pkg::ST_DRAW_PIX : sgfp_pkg::ST_DONE;
                        sgfp_pkg::OP_READ:
                            state_next = sgfp_pkg::ST_READ;
                        default:
                            state_next = sgfp_pkg::ST_DONE;
                    endcase
                end
            end
            sgfp_pkg::ST_SWEEP:
            begin
                if (sweep_last)
                    state_next = sgfp_pkg::ST_DONE;
            end
            sgfp_pkg::ST_READ:
                state_next = sgfp_pkg::ST_DONE;
            sgfp_pkg::ST_DRAW_PIX:
            begin
                if (draw_hit)
                    state_next = sgfp_pkg::ST_DRAW_WR;
                else if (step_stat.last)
                    state_next = sgfp_pkg::ST_DONE;
            end
            sgfp_pkg::ST_DRAW_WR:
                state_next = step_stat.last ? sgfp_pkg::ST_DONE : sgfp_pkg::ST_DRAW_PIX;
            sgfp_pkg::ST_DONE:
            begin
                if (done_take)
                    state_next = sgfp_pkg::ST_IDLE;
            end
            default:
                state_next = sgfp_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        cmd.ready         = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = sweep_addr_reg;
        mem_wdata         = fill_byte;
        mem_raddr         = draw_addr;
        step_ctrl.start   = 1'b0;
        step_ctrl.advance = 1'b0;
        case (state_reg)
            sgfp_pkg::ST_INIT, sgfp_pkg::ST_SWEEP:
                mem_we = 1'b1;
            sgfp_pkg::ST_IDLE:
            begin
                cmd.ready       = 1'b1;
                mem_raddr       = ADDR_W'(cmd.read_index);
                step_ctrl.start = cmd.valid && (cmd.opcode == sgfp_pkg::OP_DRAW);
            end
            sgfp_pkg::ST_DRAW_PIX:
                step_ctrl.advance = !draw_hit;
            sgfp_pkg::ST_DRAW_WR:
            begin
                mem_we            = 1'b1;
                mem_waddr         = draw_addr;
                mem_wdata         = mem_rdata_reg | draw_mask;
                step_ctrl.advance = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Frame memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= frame_mem[mem_raddr];
    end

    // Advance the state, the scale, the sweep counters, the band limits and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sgfp_pkg::ST_INIT;
            scale_reg      <= 4'd3;
            sweep_addr_reg <= '0;
            sweep_col_reg  <= '0;
            sweep_page_reg <= '0;
            fill_first_reg <= '0;
            fill_last_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
                scale_reg <= cfg.glyph_scale;

            if (state_reg == sgfp_pkg::ST_INIT || state_reg == sgfp_pkg::ST_SWEEP)
            begin
                if (sweep_last)
                begin
                    sweep_addr_reg <= '0;
                    sweep_col_reg  <= '0;
                    sweep_page_reg <= '0;
                end
                else
                begin
                    sweep_addr_reg <= sweep_addr_reg + ADDR_W'(1);
                    if (sweep_col_reg == COL_W'(DISPLAY_WIDTH - 1))
                    begin
                        sweep_col_reg  <= '0;
                        sweep_page_reg <= sweep_page_reg + PAGE_W'(1);
                    end
                    else
                        sweep_col_reg <= sweep_col_reg + COL_W'(1);
                end
            end

            if (cmd_fire)
            begin
                case (cmd.opcode)
                    sgfp_pkg::OP_FILL_TOP:
                    begin
                        fill_first_reg <= '0;
                        fill_last_reg  <= ROW_W'(SPLIT_CLIP);
                    end
                    sgfp_pkg::OP_FILL_LOW:
                    begin
                        fill_first_reg <= ROW_W'(SPLIT_CLIP);
                        fill_last_reg  <= ROW_W'(DISPLAY_HEIGHT);
                    end
                    default:
                    begin
                        fill_first_reg <= '0;
                        fill_last_reg  <= '0;
                    end
                endcase
            end

            if (done_take)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold the result of the command in flight and the output register
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            res_data_reg <= '0;
            rd_ok_reg    <= int'(cmd.read_index) < STORE_BYTES;
        end
        else if (state_reg == sgfp_pkg::ST_READ)
            res_data_reg <= rd_ok_reg ? mem_rdata_reg : 8'd0;

        if (done_take)
            out_data_reg <= res_data_reg;
    end

    assign cfg.ready     = 1'b1;
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;

endmodule

// File: sv/sgfp_glyph_step.sv
`timescale 1ns / 1ps

// Walks the glyph cell: column, row, then the scale-by-scale square of each
// lit glyph pixel, keeping the current screen coordinate with small adders.
module sgfp_glyph_step (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sgfp_pkg::step_ctrl_t                ctrl,
    input  logic [3:0]                          scale,
    input  logic signed [sgfp_pkg::X_W-1:0]     x0,
    input  logic signed [sgfp_pkg::Y_W-1:0]     y0,
    input  sgfp_pkg::glyph_t                    cols,
    output sgfp_pkg::step_stat_t                stat,
    output logic signed [sgfp_pkg::X_W-1:0]     px,
    output logic signed [sgfp_pkg::Y_W-1:0]     py
);

    sgfp_pkg::glyph_t                  cols_reg;
    logic signed [sgfp_pkg::Y_W-1:0]   y0_reg;
    logic [2:0]                        col_reg, col_next;
    logic [2:0]                        row_reg, row_next;
    logic [3:0]                        dx_reg, dx_next;
    logic [3:0]                        dy_reg, dy_next;
    logic signed [sgfp_pkg::X_W-1:0]   col_x_reg, col_x_next;
    logic signed [sgfp_pkg::Y_W-1:0]   row_y_reg, row_y_next;
    logic signed [sgfp_pkg::X_W-1:0]   cur_x_reg, cur_x_next;
    logic signed [sgfp_pkg::Y_W-1:0]   cur_y_reg, cur_y_next;

    logic [3:0]                        scale_m1;
    logic signed [sgfp_pkg::X_W-1:0]   step_x;
    logic signed [sgfp_pkg::Y_W-1:0]   step_y;
    logic                              lit;
    logic                              sq_end;
    logic                              glyph_end;
    logic                              next_glyph;

    // Decode the current position
    assign scale_m1   = scale - 4'd1;
    assign step_x     = $signed(sgfp_pkg::X_W'(scale));
    assign step_y     = $signed(sgfp_pkg::Y_W'(scale));
    assign lit        = cols_reg[col_reg][row_reg];
    assign sq_end     = (dx_reg == scale_m1) && (dy_reg == scale_m1);
    assign glyph_end  = (col_reg == 3'(sgfp_pkg::GLYPH_COLS - 1)) &&
                        (row_reg == 3'(sgfp_pkg::GLYPH_ROWS - 1));
    assign next_glyph = !lit || sq_end;

    assign stat.lit  = lit;
    assign stat.last = glyph_end && next_glyph;
    assign px        = cur_x_reg;
    assign py        = cur_y_reg;

    // Advance to the next square pixel or the next glyph pixel
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        col_x_next = col_x_reg;
        row_y_next = row_y_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        if (ctrl.start)
        begin
            col_next   = '0;
            row_next   = '0;
            dx_next    = '0;
            dy_next    = '0;
            col_x_next = x0;
            row_y_next = y0;
            cur_x_next = x0;
            cur_y_next = y0;
        end
        else if (ctrl.advance)
        begin
            if (next_glyph)
            begin
                dx_next = '0;
                dy_next = '0;
                if (row_reg == 3'(sgfp_pkg::GLYPH_ROWS - 1))
                begin
                    row_next   = '0;
                    col_next   = col_reg + 3'd1;
                    col_x_next = col_x_reg + step_x;
                    row_y_next = y0_reg;
                    cur_x_next = col_x_next;
                    cur_y_next = y0_reg;
                end
                else
                begin
                    row_next   = row_reg + 3'd1;
                    row_y_next = row_y_reg + step_y;
                    cur_x_next = col_x_reg;
                    cur_y_next = row_y_next;
                end
            end
            else if (dx_reg == scale_m1)
            begin
                dx_next    = '0;
                dy_next    = dy_reg + 4'd1;
                cur_x_next = col_x_reg;
                cur_y_next = cur_y_reg + sgfp_pkg::Y_W'(1);
            end
            else
            begin
                dx_next    = dx_reg + 4'd1;
                cur_x_next = cur_x_reg + sgfp_pkg::X_W'(1);
            end
        end
    end

    // Hold the position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            dx_reg  <= '0;
            dy_reg  <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
        end
    end

    // Hold the coordinates and the glyph bitmap
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            cols_reg <= cols;
            y0_reg   <= y0;
        end
        col_x_reg <= col_x_next;
        row_y_reg <= row_y_next;
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
    end

endmodule

// File: bench/tb_scaled_glyph_framebuffer_painter.sv
`timescale 1ns / 1ps

module tb_scaled_glyph_framebuffer_painter;

    // Display geometry of the default build
    localparam int DISP_W      = 128;
    localparam int DISP_H      = 64;
    localparam int SPLIT_ROW   = 16;
    localparam int STORE_BYTES = DISP_W * ((DISP_H + 7) / 8);
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int DRAIN_WAIT  = 64;
    localparam int LONG_HOLD   = 400;

    // Opcodes the block does not define
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        logic [2:0] op;
        logic [7:0] code;
        logic [9:0] x;
        logic [7:0] y;
        logic [9:0] idx;
        bit         fixed;
        logic [7:0] value;
    } cmd_row_t;

    typedef struct {
        bit         fixed;
        logic [7:0] value;
    } fixed_byte_t;

    logic clk;
    logic rst_n;

    sgfp_cmd_if cmd_ch ();
    sgfp_rsp_if rsp_ch ();
    sgfp_cfg_if cfg_ch ();

    scaled_glyph_framebuffer_painter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow framebuffer and scale register
    logic [7:0]  frame_model [STORE_BYTES];
    logic [3:0]  scale_model = 4'd3;

    logic [7:0]  expected_bytes [$];
    fixed_byte_t fixed_bytes_q [$];
    cmd_row_t    directed_rows [$];
    logic [7:0]  font_codes [$];

    int  n_issued    = 0;
    int  n_checked   = 0;
    int  n_errors    = 0;
    int  cycle_count = 0;
    int  op_count [8];
    bit  idle_on     = 1'b1;
    bit  hold_req    = 1'b0;
    bit  hold_active = 1'b0;
    int  rsp_gap     = 0;
    int  last_x      = 0;
    int  last_y      = 0;

    // Font ROM bitmaps, columns 0..4 from the top bits down
    function automatic logic [34:0] glyph_bitmap(input logic [7:0] code, output bit known);
        known = 1'b1;
        case (code)
            8'h20: return {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
            8'h2C: return {7'h00, 7'h50, 7'h30, 7'h00, 7'h00};
            8'h48: return {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
            8'h49: return {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
            8'h52: return {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
            8'h53: return {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
            8'h54: return {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
            8'h61: return {7'h20, 7'h54, 7'h54, 7'h54, 7'h78};
            8'h65: return {7'h38, 7'h54, 7'h54, 7'h54, 7'h18};
            8'h68: return {7'h7F, 7'h08, 7'h04, 7'h04, 7'h78};
            8'h69: return {7'h00, 7'h44, 7'h7D, 7'h40, 7'h00};
            8'h6B: return {7'h7F, 7'h10, 7'h28, 7'h44, 7'h00};
            8'h6C: return {7'h00, 7'h41, 7'h7F, 7'h40, 7'h00};
            8'h6D: return {7'h7C, 7'h04, 7'h18, 7'h04, 7'h78};
            8'h6E: return {7'h7C, 7'h08, 7'h04, 7'h04, 7'h78};
            8'h6F: return {7'h38, 7'h44, 7'h44, 7'h44, 7'h38};
            8'h72: return {7'h7C, 7'h08, 7'h04, 7'h04, 7'h08};
            8'h74: return {7'h04, 7'h3F, 7'h44, 7'h40, 7'h20};
            8'h79: return {7'h0C, 7'h50, 7'h50, 7'h50, 7'h3C};
            default:
            begin
                known = 1'b0;
                return '0;
            end
        endcase
    endfunction

    // Set one pixel, skip anything off the display
    function automatic void light_pixel(input int px, input int py);
        if (px < 0 || px >= DISP_W || py < 0 || py >= DISP_H)
            return;
        frame_model[(py >> 3) * DISP_W + px] |= 8'(1 << (py & 7));
    endfunction

    function automatic void clear_frame();
        for (int i = 0; i < STORE_BYTES; i++)
            frame_model[i] = 8'h00;
    endfunction

    // Apply one command to the shadow buffer and return the byte it reports
    function automatic logic [7:0] paint_and_read(input logic [2:0] op,
                                                  input logic [7:0] code,
                                                  input logic signed [9:0] x,
                                                  input logic signed [7:0] y,
                                                  input logic [9:0] idx);
        logic [34:0] bits;
        logic [6:0]  column;
        bit          known;
        int          s;
        logic [7:0]  data;
        data = 8'h00;
        case (op)
            sgfp_pkg::OP_CLEAR: clear_frame();
            sgfp_pkg::OP_FILL_TOP:
            begin
                clear_frame();
                for (int r = 0; r < SPLIT_ROW; r++)
                    for (int c = 0; c < DISP_W; c++)
                        light_pixel(c, r);
            end
            sgfp_pkg::OP_FILL_LOW:
            begin
                clear_frame();
                for (int r = SPLIT_ROW; r < DISP_H; r++)
                    for (int c = 0; c < DISP_W; c++)
                        light_pixel(c, r);
            end
            sgfp_pkg::OP_DRAW:
            begin
                bits = glyph_bitmap(code, known);
                s = int'(scale_model);
                if (known)
                begin
                    for (int c = 0; c < sgfp_pkg::GLYPH_COLS; c++)
                    begin
                        column = bits[(sgfp_pkg::GLYPH_COLS - 1 - c) * sgfp_pkg::GLYPH_ROWS
                                      +: sgfp_pkg::GLYPH_ROWS];
                        for (int r = 0; r < sgfp_pkg::GLYPH_ROWS; r++)
                            if (column[r])
                                for (int dy = 0; dy < s; dy++)
                                    for (int dx = 0; dx < s; dx++)
                                        light_pixel(int'(x) + c * s + dx,
                                                    int'(y) + r * s + dy);
                    end
                end
            end
            sgfp_pkg::OP_READ:
                if (int'(idx) < STORE_BYTES)
                    data = frame_model[idx];
            default: ;
        endcase
        return data;
    endfunction

    task automatic add_row(input logic [2:0] op, input logic [7:0] code, input int x,
                           input int y, input int idx, input bit fixed,
                           input logic [7:0] value);
        cmd_row_t row;
        row.op    = op;
        row.code  = code;
        row.x     = x[9:0];
        row.y     = y[7:0];
        row.idx   = idx[9:0];
        row.fixed = fixed;
        row.value = value;
        directed_rows.push_back(row);
    endtask

    // Offer one command, with an optional idle burst first
    task automatic send_cmd(input logic [2:0] op, input logic [7:0] code,
                            input logic [9:0] x, input logic [7:0] y,
                            input logic [9:0] idx, input bit fixed,
                            input logic [7:0] value);
        fixed_byte_t fb;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        fb.fixed = fixed;
        fb.value = value;
        fixed_bytes_q.push_back(fb);
        n_issued++;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= op;
        cmd_ch.char_code  <= code;
        cmd_ch.x_pos      <= x;
        cmd_ch.y_pos      <= y;
        cmd_ch.read_index <= idx;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // Drop valid and wait until every response is back
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (n_checked != n_issued)
            @(posedge clk);
    endtask

    task automatic write_scale(input logic [3:0] value);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.glyph_scale <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random command, mostly reads and draws, often near the panel and near the last glyph
    task automatic send_random_item();
        int         pick;
        int         page;
        logic [2:0] op;
        logic [7:0] code;
        logic [9:0] x;
        logic [7:0] y;
        logic [9:0] idx;
        pick = $urandom_range(0, 99);
        code = 8'($urandom);
        x    = 10'($urandom);
        y    = 8'($urandom);
        idx  = 10'($urandom);
        if (pick < 45)
        begin
            op = sgfp_pkg::OP_READ;
            if ($urandom_range(0, 1) == 0)
            begin
                page = ((last_y >>> 3) + $urandom_range(0, 3)) & 7;
                idx  = 10'(page * DISP_W + ((last_x + $urandom_range(0, 40)) & (DISP_W - 1)));
            end
        end
        else if (pick < 85)
        begin
            op = sgfp_pkg::OP_DRAW;
            if ($urandom_range(0, 3) != 0)
                code = font_codes[$urandom_range(0, font_codes.size() - 1)];
            if ($urandom_range(0, 4) != 0)
            begin
                x = 10'($urandom_range(0, 160) - 20);
                y = 8'($urandom_range(0, 90) - 20);
            end
            last_x = int'($signed(x));
            last_y = int'($signed(y));
        end
        else if (pick < 90)
            op = sgfp_pkg::OP_CLEAR;
        else if (pick < 93)
            op = sgfp_pkg::OP_FILL_TOP;
        else if (pick < 96)
            op = sgfp_pkg::OP_FILL_LOW;
        else
            op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
        send_cmd(op, code, x, y, idx, 1'b0, 8'h00);
    endtask

    task automatic run_phase(input logic [3:0] scale, input int count);
        wait_idle();
        write_scale(scale);
        repeat (count) send_random_item();
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Guard against a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                     $time, cycle_count, n_issued - n_checked);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Hold off the response side for a long stretch once asked
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_active = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
    end

    // Response ready with random stall bursts
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_active || rsp_gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                if (rsp_gap > 0)
                    rsp_gap--;
            end
            else if (idle_on && $urandom_range(0, 6) == 0)
            begin
                rsp_gap = $urandom_range(1, 17) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watch all three channels: check responses, track config, predict commands
    always @(posedge clk)
    begin : watch
        logic [7:0]  want;
        logic [7:0]  predicted;
        fixed_byte_t fb;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual read_data %02h",
                         $time, rsp_ch.read_data);
                n_errors++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (rsp_ch.read_data !== want)
                begin
                    $display("%0t: response %0d read_data mismatch, expected %02h actual %02h",
                             $time, n_checked, want, rsp_ch.read_data);
                    n_errors++;
                end
                n_checked++;
            end
        end
        if (cfg_ch.valid && cfg_ch.ready)
            scale_model = cfg_ch.glyph_scale;
        if (cmd_ch.valid && cmd_ch.ready)
        begin
            fb = fixed_bytes_q.pop_front();
            predicted = paint_and_read(cmd_ch.opcode, cmd_ch.char_code, cmd_ch.x_pos,
                                       cmd_ch.y_pos, cmd_ch.read_index);
            expected_bytes.push_back(fb.fixed ? fb.value : predicted);
            op_count[cmd_ch.opcode]++;
        end
    end

    // Stimulus
    initial
    begin
        bit known;
        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.opcode      <= sgfp_pkg::OP_CLEAR;
        cmd_ch.char_code   <= 8'h00;
        cmd_ch.x_pos       <= '0;
        cmd_ch.y_pos       <= '0;
        cmd_ch.read_index  <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.glyph_scale <= 4'd3;
        clear_frame();
        for (int i = 0; i < 8; i++)
            op_count[i] = 0;
        for (int c = 0; c < 256; c++)
            if (glyph_bitmap(8'(c), known) || known)
                font_codes.push_back(8'(c));

        // Directed rows: reset state, bands, clipping, unknown glyphs, spare opcodes
        add_row(sgfp_pkg::OP_READ,     8'h00, 0,    0,    0,    1, 8'h00);
        add_row(sgfp_pkg::OP_READ,     8'h00, 0,    0,    1023, 1, 8'h00);
        add_row(OP_SPARE_5,            8'hFF, -1,   -1,   1023, 1, 8'h00);
        add_row(OP_SPARE_7,            8'h48, 511,  127,  0,    1, 8'h00);
        add_row(sgfp_pkg::OP_FILL_TOP, 8'h00, 0,    0,    0,    1, 8'h00);
        add_row(sgfp_pkg::OP_READ,     8'h00, 0,    0,    0,    1, 8'hFF);
        add_row(sgfp_pkg::OP_READ,     8'h00, 0,    0,    255,  1, 8'hFF);
        add_row(sgfp_pkg::OP_READ,     8'h00, 0,    0,    256,  1, 8'h00);
        add_row(sgfp_pkg::OP_FILL_LOW, 8'h00, 0,    0,    0,    1, 8'h00);
        add_row(sgfp_pkg::OP_READ,     8'h00, 0,    0,    0,    1, 8'h00);
        add_row(sgfp_pkg::OP_READ,     8'h00, 0,    0,    256,  1, 8'hFF);
        add_row(sgfp_pkg::OP_READ,     8'h00, 0,    0,    1023, 1, 8'hFF);
        add_row(sgfp_pkg::OP_CLEAR,    8'h00, 0,    0,    0,    1, 8'h00);
        add_row(sgfp_pkg::OP_READ,     8'h00, 0,    0,    1023, 1, 8'h00);
        // 'H' in the top left corner at the reset scale
        add_row(sgfp_pkg::OP_DRAW,     8'h48, 0,    0,    0,    1, 8'h00);
        add_row(sgfp_pkg::OP_READ,     8'h00, 0,    0,    0,    0, 8'h00);
        add_row(sgfp_pkg::OP_READ,     8'h00, 0,    0,    129,  0, 8'h00);
        // codes missing from the font and the blank glyph
        add_row(sgfp_pkg::OP_DRAW,     8'h00, 10,   10,   0,    1, 8'h00);
        add_row(sgfp_pkg::OP_DRAW,     8'hFF, 10,   10,   0,    1, 8'h00);
        add_row(sgfp_pkg::OP_DRAW,     8'h20, 60,   30,   0,    1, 8'h00);
        // extreme and partly clipped positions
        add_row(sgfp_pkg::OP_DRAW,     8'h61, -512, -128, 0,    1, 8'h00);
        add_row(sgfp_pkg::OP_DRAW,     8'h54, 511,  127,  0,    1, 8'h00);
        add_row(sgfp_pkg::OP_DRAW,     8'h79, 120,  58,   0,    1, 8'h00);
        add_row(sgfp_pkg::OP_DRAW,     8'h69, -4,   -5,   0,    1, 8'h00);
        add_row(sgfp_pkg::OP_READ,     8'h00, 0,    0,    1019, 0, 8'h00);
        add_row(sgfp_pkg::OP_READ,     8'h00, 0,    0,    0,    0, 8'h00);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].op, directed_rows[i].code, directed_rows[i].x,
                     directed_rows[i].y, directed_rows[i].idx, directed_rows[i].fixed,
                     directed_rows[i].value);

        // Random phases over several scales; stall the response side early on
        wait_idle();
        write_scale(4'd1);
        hold_req = 1'b1;
        repeat (150) send_random_item();
        run_phase(4'd8,  150);
        run_phase(4'd0,  40);
        run_phase(4'd15, 30);
        run_phase(4'd7,  120);
        run_phase(4'd2,  150);
        // final stretch at full rate
        wait_idle();
        idle_on = 1'b0;
        write_scale(4'd3);
        repeat (190) send_random_item();

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_bytes.size() != 0)
        begin
            $display("%0t: %0d responses never arrived, expected %02h actual none",
                     $time, expected_bytes.size(), expected_bytes[0]);
            n_errors++;
        end
        $display("Covered %0d commands: %0d draws, %0d reads, %0d clears/fills, %0d spare",
                 n_issued, op_count[sgfp_pkg::OP_DRAW], op_count[sgfp_pkg::OP_READ],
                 op_count[sgfp_pkg::OP_CLEAR] + op_count[sgfp_pkg::OP_FILL_TOP] +
                 op_count[sgfp_pkg::OP_FILL_LOW],
                 op_count[OP_SPARE_5] + op_count[OP_SPARE_6] + op_count[OP_SPARE_7]);
        $display("Scales 3, 1, 8, 0, 15, 7, 2 exercised; %0d responses compared, %0d errors",
                 n_checked, n_errors);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
